// File: design/assert_macros.svh
// Assertion macros shared by the oscillator RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds whenever the antecedent holds
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/wto_pkg.sv
// Types, constants and functions for the wavetable oscillator.
// No dependencies; used by wavetable_oscillator_sample.
package wto_pkg;

  // Waveform codes held in the wave select register
  typedef enum logic [1:0] {
    SHAPE_SINE  = 2'd0,
    SHAPE_TRI   = 2'd1,
    SHAPE_RAMP  = 2'd2,
    SHAPE_PULSE = 2'd3
  } wave_e;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned SAMPLE_W    = 16;
  // Polynomial datapath width: holds 24 * 32767 with sign
  localparam int unsigned P_W         = 22;
  localparam int unsigned QUARTER     = TABLE_DEPTH / 4;
  localparam int unsigned QIDX_W      = $clog2(QUARTER + 1);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // First quadrant of the sine table, round(32767*sin(2*pi*k/256))
  localparam logic [14:0] QUARTER_SINE [0:QUARTER] = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
    15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
    15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
    15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
    15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
    15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
    15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
    15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
    15'd32757, 15'd32767
  };

  // Full-cycle sine entry built from the quarter-wave table
  function automatic logic signed [SAMPLE_W-1:0] sine_rom(input logic [IDX_W-1:0] idx);
    logic [1:0]              quad;
    logic [QIDX_W-1:0]       k;
    logic signed [SAMPLE_W-1:0] v;
    quad = idx[IDX_W-1 -: 2];
    k    = {1'b0, idx[IDX_W-3:0]};
    if (quad[0]) begin
      v = signed'({1'b0, QUARTER_SINE[QIDX_W'(QUARTER) - k]});
    end else begin
      v = signed'({1'b0, QUARTER_SINE[k]});
    end
    return quad[1] ? -v : v;
  endfunction

  // One Horner step: floor(p * t / 256) + a
  function automatic logic signed [P_W-1:0] horner_step(
    input logic signed [P_W-1:0] p,
    input logic [FRAC_W-1:0]     t,
    input logic signed [P_W-1:0] a
  );
    logic signed [P_W+FRAC_W:0] prod;
    prod = p * signed'({1'b0, t});
    return signed'(prod[P_W+FRAC_W-1:FRAC_W]) + a;
  endfunction

endpackage

// File: design/wavetable_oscillator_sample.sv
// Wavetable oscillator: phase in, one signed 16-bit sample out.
// Depends on wto_pkg and assert_macros.svh.
//
// Usage:
//   Input channel phase_valid_i / phase_ready_o carries one 32-bit phase
//   value per request; output channel sample_valid_o / sample_ready_i
//   carries one signed 16-bit sample per request, in input order.
//   cfg_we_i / cfg_wdata_i write the waveform select (0 sine, 1 triangle,
//   2 saw, 3 square); the value is taken with each phase as it enters.
// Timing:
//   Five register stages: table lookup, coefficients, two Horner steps,
//   last Horner step with saturation into the output register. One phase
//   is accepted every cycle while the receiver keeps up.
//   The three sequential multiply-adds of the cubic set the depth.
// Reset:
//   rst_ni clears all valid bits and selects sine; no clearing pass.
// Back-pressure:
//   When sample_ready_i is low the output holds; empty stages still fill,
//   and phase_ready_o drops only once every stage holds a request.
module wavetable_oscillator_sample
  import wto_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  input  logic                       phase_valid_i,
  output logic                       phase_ready_o,
  input  logic [31:0]                phase_i,
  output logic                       sample_valid_o,
  input  logic                       sample_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  `include "assert_macros.svh"

  wave_e wave_sel_q;

  // Stage valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en_out;

  // Stage 1: table entries
  wave_e                      mode1_q;
  logic [FRAC_W-1:0]          t1_q;
  logic signed [SAMPLE_W-1:0] y0_q, y1_q, y2_q, y3_q;
  logic signed [SAMPLE_W-1:0] direct1_q;

  // Stage 2: coefficients
  wave_e                      mode2_q;
  logic [FRAC_W-1:0]          t2_q;
  logic signed [P_W-1:0]      a0_q, a1_q, a2_q, a3_q;
  logic signed [SAMPLE_W-1:0] direct2_q;

  // Stage 3: first Horner step
  wave_e                      mode3_q;
  logic [FRAC_W-1:0]          t3_q;
  logic signed [P_W-1:0]      p1_q, a2_3_q, a3_3_q;
  logic signed [SAMPLE_W-1:0] direct3_q;

  // Stage 4: second Horner step
  wave_e                      mode4_q;
  logic [FRAC_W-1:0]          t4_q;
  logic signed [P_W-1:0]      p2_q, a3_4_q;
  logic signed [SAMPLE_W-1:0] direct4_q;

  // Output register
  wave_e                      out_mode_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  logic [IDX_W-1:0]           idx;
  logic [SAMPLE_W-1:0]        ramp;
  logic [SAMPLE_W-2:0]        fold;
  logic signed [SAMPLE_W-1:0] direct_d;
  logic signed [P_W-1:0]      y0e, y1e, y2e, y3e;
  logic signed [P_W-1:0]      p3, half;
  logic signed [SAMPLE_W-1:0] sine_d, sample_d;

  // Advance a stage when it is empty or the next one advances
  assign en_out        = !out_v_q || sample_ready_i;
  assign en4           = !v4_q || en_out;
  assign en3           = !v3_q || en4;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign phase_ready_o = en1;

  // Waveform select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel_q <= SHAPE_SINE;
    end else if (cfg_we_i) begin
      wave_sel_q <= wave_e'(cfg_wdata_i);
    end
  end

  // Valid bits travel with the requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= phase_valid_i;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en4)    v4_q    <= v3_q;
      if (en_out) out_v_q <= v4_q;
    end
  end

  // Non-sine waveforms straight from the phase bits
  always_comb begin
    idx  = phase_i[31 -: IDX_W];
    ramp = phase_i[31:16];
    // 65535 - r equals the bitwise inverse for a 16-bit r
    fold = ramp[SAMPLE_W-1] ? ~ramp[SAMPLE_W-2:0] : ramp[SAMPLE_W-2:0];
    case (wave_sel_q)
      SHAPE_TRI:   direct_d = signed'({fold, 1'b0}) - SAMPLE_MAX;
      SHAPE_RAMP:  direct_d = signed'({~ramp[SAMPLE_W-1], ramp[SAMPLE_W-2:0]});
      SHAPE_PULSE: direct_d = phase_i[31] ? SAMPLE_MAX : SAMPLE_MIN;
      default:     direct_d = SAMPLE_MIN;
    endcase
  end

  // Stage 1: read four neighbouring table entries, wrapping at the ends
  always_ff @(posedge clk_i) begin
    if (en1 && phase_valid_i) begin
      mode1_q   <= wave_sel_q;
      t1_q      <= phase_i[31-IDX_W -: FRAC_W];
      y0_q      <= sine_rom(idx - IDX_W'(1));
      y1_q      <= sine_rom(idx);
      y2_q      <= sine_rom(idx + IDX_W'(1));
      y3_q      <= sine_rom(idx + IDX_W'(2));
      direct1_q <= direct_d;
    end
  end

  // Stage 2: Catmull-Rom coefficients
  assign y0e = P_W'(y0_q);
  assign y1e = P_W'(y1_q);
  assign y2e = P_W'(y2_q);
  assign y3e = P_W'(y3_q);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mode2_q   <= mode1_q;
      t2_q      <= t1_q;
      a0_q      <= P_W'((y3e - y0e) + 3 * (y1e - y2e));
      a1_q      <= P_W'((2 * y0e + 4 * y2e) - (5 * y1e + y3e));
      a2_q      <= y2e - y0e;
      a3_q      <= P_W'(2 * y1e);
      direct2_q <= direct1_q;
    end
  end

  // Stage 3: first multiply-add
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      mode3_q   <= mode2_q;
      t3_q      <= t2_q;
      p1_q      <= horner_step(a0_q, t2_q, a1_q);
      a2_3_q    <= a2_q;
      a3_3_q    <= a3_q;
      direct3_q <= direct2_q;
    end
  end

  // Stage 4: second multiply-add
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      mode4_q   <= mode3_q;
      t4_q      <= t3_q;
      p2_q      <= horner_step(p1_q, t3_q, a2_3_q);
      a3_4_q    <= a3_3_q;
      direct4_q <= direct3_q;
    end
  end

  // Last multiply-add, halve and saturate
  always_comb begin
    p3   = horner_step(p2_q, t4_q, a3_4_q);
    half = p3 >>> 1;
    if (half > P_W'(SAMPLE_MAX)) begin
      sine_d = SAMPLE_MAX;
    end else if (half < P_W'(SAMPLE_MIN)) begin
      sine_d = SAMPLE_MIN;
    end else begin
      sine_d = half[SAMPLE_W-1:0];
    end
    sample_d = (mode4_q == SHAPE_SINE) ? sine_d : direct4_q;
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (en_out && v4_q) begin
      out_mode_q <= mode4_q;
      sample_q   <= sample_d;
    end
  end

  assign sample_valid_o = out_v_q;
  assign sample_o       = sample_q;

  // Input stalls only when the whole pipeline is full and the output blocked
  `ASSERT_IMPL(a_stall_cause, !phase_ready_o,
    v1_q && v2_q && v3_q && v4_q && sample_valid_o && !sample_ready_i,
    "input stalled without output back-pressure")

  // A new output request comes only from the last pipeline stage
  `ASSERT_IMPL(a_out_source, $rose(sample_valid_o), $past(v4_q),
    "output valid rose without a request in stage 4")

  // Square samples are always full scale
  `ASSERT_IMPL(a_square_level, sample_valid_o && out_mode_q == SHAPE_PULSE,
    sample_o == SAMPLE_MAX || sample_o == SAMPLE_MIN,
    "square sample not at full scale")

endmodule
